// ===== design/brl_pkg.sv =====
// Shared types and constants for the Bresenham line rasteriser.
// Depends on nothing; used by brl_dstep, bresenham_line_rasterizer and the bench.
package brl_pkg;

    // Coordinate, colour and index widths fixed by the pixel format.
    localparam int COORD_W = 6;
    localparam int COLOR_W = 8;
    localparam int DIM_W   = 7;
    localparam int INDEX_W = 12;
    // Decision variable and its increments stay within -126..126.
    localparam int D_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ORDER = 4'b0010,
        ST_PREP  = 4'b0100,
        ST_RUN   = 4'b1000
    } state_t;

    // Increments applied to the decision variable, chosen per step.
    typedef struct packed {
        logic signed [D_W-1:0] inc_move;
        logic signed [D_W-1:0] inc_stay;
    } dstep_inc_t;

endpackage

// ===== design/brl_dstep.sv =====
// Decision-variable step unit: one compare and one add per major-axis step.
// Depends on brl_pkg for widths and the increment struct.
module brl_dstep
(
    input  logic signed [brl_pkg::D_W-1:0] d,
    input  brl_pkg::dstep_inc_t            inc,
    output logic signed [brl_pkg::D_W-1:0] d_next,
    output logic                           move
);

    always_comb
    begin
        move   = (d > $signed(brl_pkg::D_W'(0)));
        d_next = d + (move ? inc.inc_move : inc.inc_stay);
    end

endmodule

// ===== design/bresenham_line_rasterizer.sv =====
// Top level of the Bresenham line rasteriser: sequencer, set-up and pixel output.
// Depends on brl_pkg and brl_dstep.
//
//  channel    | handshake                   | payload
//  -----------+-----------------------------+----------------------------------------
//  request    | start, busy                 | start_x/y, end_x/y, red/green/blue/alpha_in
//  result     | pixel_valid (strobe)        | pixel_x/y, pixel_index, visible, colour, last_pixel
//  config     | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. The set-up states ORDER and PREP
// follow, then one pixel per cycle along the major axis in RUN. The result strobe is
// registered from each step and rises in the cycle after it.
// Reset clears the sequencer and sets both target dimensions to 64.
// The receiver cannot stall; the configuration port is always ready.
module bresenham_line_rasterizer
#(
    parameter int TILE_SIZE = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [brl_pkg::COORD_W-1:0]        start_x,
    input  logic [brl_pkg::COORD_W-1:0]        start_y,
    input  logic [brl_pkg::COORD_W-1:0]        end_x,
    input  logic [brl_pkg::COORD_W-1:0]        end_y,
    input  logic [brl_pkg::COLOR_W-1:0]        red_in,
    input  logic [brl_pkg::COLOR_W-1:0]        green_in,
    input  logic [brl_pkg::COLOR_W-1:0]        blue_in,
    input  logic [brl_pkg::COLOR_W-1:0]        alpha_in,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [brl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brl_pkg::DIM_W-1:0]          cfg_data,
    output logic                               pixel_valid,
    output logic [brl_pkg::COORD_W-1:0]        pixel_x,
    output logic [brl_pkg::COORD_W-1:0]        pixel_y,
    output logic [brl_pkg::INDEX_W-1:0]        pixel_index,
    output logic                               visible,
    output logic [brl_pkg::COLOR_W-1:0]        red_out,
    output logic [brl_pkg::COLOR_W-1:0]        green_out,
    output logic [brl_pkg::COLOR_W-1:0]        blue_out,
    output logic [brl_pkg::COLOR_W-1:0]        alpha_out,
    output logic                               last_pixel
);

    localparam int CW = brl_pkg::COORD_W;
    localparam int DW = brl_pkg::D_W;
    localparam logic [CW:0]   TILE_LIMIT = (CW+1)'(TILE_SIZE);
    localparam logic [CW-1:0] TILE_MAX   = CW'(TILE_SIZE - 1);

    brl_pkg::state_t state_reg, state_next;

    logic [brl_pkg::DIM_W-1:0] width_reg, height_reg;

    // Captured request
    logic [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [brl_pkg::COLOR_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    // Ordered major/minor endpoints
    logic          steep_reg;
    logic [CW-1:0] maj0_reg, maj1_reg, min0_reg, min1_reg;

    // Stepping state
    logic [CW-1:0]         maj_reg, mn_reg;
    logic                  step_neg_reg;
    logic signed [DW-1:0]  d_reg;
    brl_pkg::dstep_inc_t   inc_reg;

    // Output registers
    logic                          pixel_valid_reg;
    logic [CW-1:0]                 pixel_x_reg, pixel_y_reg;
    logic [brl_pkg::INDEX_W-1:0]   pixel_index_reg;
    logic                          visible_reg, last_reg;

    logic accept;
    assign accept    = start && (state_reg == brl_pkg::ST_IDLE);
    assign busy      = (state_reg != brl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        r = ({1'b0, v} >= TILE_LIMIT) ? TILE_MAX : v;
        return r;
    endfunction

    // Ordering stage
    logic signed [CW:0] dx_s, dy_s;
    logic [CW:0]        adx, ady;
    logic               steep_c;
    logic [CW-1:0]      a0, a1, b0, b1;
    logic               swap_c;

    always_comb
    begin
        dx_s    = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
        dy_s    = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
        adx     = dx_s[CW] ? (CW+1)'(-dx_s) : (CW+1)'(dx_s);
        ady     = dy_s[CW] ? (CW+1)'(-dy_s) : (CW+1)'(dy_s);
        steep_c = (ady >= adx);
        a0      = steep_c ? y0_reg : x0_reg;
        b0      = steep_c ? x0_reg : y0_reg;
        a1      = steep_c ? y1_reg : x1_reg;
        b1      = steep_c ? x1_reg : y1_reg;
        swap_c  = (a1 < a0);
    end

    // Preparation stage: deltas, initial decision value and increments
    logic [CW-1:0]        dmaj;
    logic signed [CW:0]   dmin_s;
    logic [CW-1:0]        dmin;
    logic signed [DW-1:0] d_init;
    brl_pkg::dstep_inc_t  inc_c;

    always_comb
    begin
        dmaj   = maj1_reg - maj0_reg;
        dmin_s = $signed({1'b0, min1_reg}) - $signed({1'b0, min0_reg});
        dmin   = dmin_s[CW] ? CW'(-dmin_s) : CW'(dmin_s);
        d_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        inc_c.inc_move = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
        inc_c.inc_stay = $signed({2'b00, dmin, 1'b0});
    end

    // Shared decision step
    logic signed [DW-1:0] d_step;
    logic                 move;

    brl_dstep u_dstep
    (
        .d      (d_reg),
        .inc    (inc_reg),
        .d_next (d_step),
        .move   (move)
    );

    // Pixel of the current step
    logic [CW-1:0]               px, py;
    logic [2*CW:0]               prod;
    logic [brl_pkg::INDEX_W-1:0] idx;
    logic                        vis, at_end;

    always_comb
    begin
        px     = steep_reg ? mn_reg : maj_reg;
        py     = steep_reg ? maj_reg : mn_reg;
        prod   = (2*CW+1)'(py) * (2*CW+1)'(width_reg);
        idx    = brl_pkg::INDEX_W'(prod + (2*CW+1)'(px));
        vis    = ({1'b0, px} < width_reg) && ({1'b0, py} < height_reg);
        at_end = (maj_reg == maj1_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brl_pkg::ST_IDLE:  if (start) state_next = brl_pkg::ST_ORDER;
            brl_pkg::ST_ORDER: state_next = brl_pkg::ST_PREP;
            brl_pkg::ST_PREP:  state_next = brl_pkg::ST_RUN;
            brl_pkg::ST_RUN:   if (at_end) state_next = brl_pkg::ST_IDLE;
            default:           state_next = brl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= brl_pkg::ST_IDLE;
            width_reg       <= 7'd64;
            height_reg      <= 7'd64;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_valid_reg <= (state_reg == brl_pkg::ST_RUN);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == brl_pkg::REG_TARGET_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == brl_pkg::REG_TARGET_HEIGHT)
                    height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg    <= clamp_coord(start_x);
            y0_reg    <= clamp_coord(start_y);
            x1_reg    <= clamp_coord(end_x);
            y1_reg    <= clamp_coord(end_y);
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            alpha_reg <= alpha_in;
        end

        if (state_reg == brl_pkg::ST_ORDER)
        begin
            steep_reg <= steep_c;
            maj0_reg  <= swap_c ? a1 : a0;
            min0_reg  <= swap_c ? b1 : b0;
            maj1_reg  <= swap_c ? a0 : a1;
            min1_reg  <= swap_c ? b0 : b1;
        end

        if (state_reg == brl_pkg::ST_PREP)
        begin
            maj_reg      <= maj0_reg;
            mn_reg       <= min0_reg;
            step_neg_reg <= dmin_s[CW];
            d_reg        <= d_init;
            inc_reg      <= inc_c;
        end

        if (state_reg == brl_pkg::ST_RUN)
        begin
            maj_reg <= maj_reg + CW'(1);
            d_reg   <= d_step;
            if (move)
                mn_reg <= step_neg_reg ? mn_reg - CW'(1) : mn_reg + CW'(1);

            pixel_x_reg     <= px;
            pixel_y_reg     <= py;
            pixel_index_reg <= idx;
            visible_reg     <= vis;
            last_reg        <= at_end;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_index = pixel_index_reg;
    assign visible     = visible_reg;
    assign last_pixel  = last_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign alpha_out   = alpha_reg;

`ifndef SYNTHESIS
    // Every result comes from a stepping cycle.
    a_strobe_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> $past(state_reg == brl_pkg::ST_RUN))
        else $error("result strobe without a stepping cycle");

    // The final pixel leaves the sequencer idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && last_pixel |-> !busy)
        else $error("sequencer still busy after the final pixel");

    // A pixel that is not the last is followed at once by another.
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !last_pixel |=> pixel_valid)
        else $error("segment ended without a final pixel");

    // An accepted request occupies the block for the set-up cycles.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 busy)
        else $error("request accepted without set-up");
`endif

endmodule

// ===== bench/tb_bresenham_line_rasterizer.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bresenham_line_rasterizer: segments in, predicted pixel stream out.
// Depends on brl_pkg and the rasteriser RTL; a clocked driver and monitor share queues with
// the sequencing initial block.
module tb_bresenham_line_rasterizer;

    localparam int COORD_W   = brl_pkg::COORD_W;
    localparam int COLOR_W   = brl_pkg::COLOR_W;
    localparam int DIM_W     = brl_pkg::DIM_W;
    localparam int INDEX_W   = brl_pkg::INDEX_W;
    localparam int CFG_IDX_W = brl_pkg::CFG_IDX_W;

    localparam int TILE = 64;
    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } segment_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] lin_index;
        logic               visible;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        logic               last_flag;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [COORD_W-1:0]   start_x = '0;
    logic [COORD_W-1:0]   start_y = '0;
    logic [COORD_W-1:0]   end_x = '0;
    logic [COORD_W-1:0]   end_y = '0;
    logic [COLOR_W-1:0]   red_in = '0;
    logic [COLOR_W-1:0]   green_in = '0;
    logic [COLOR_W-1:0]   blue_in = '0;
    logic [COLOR_W-1:0]   alpha_in = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = brl_pkg::REG_TARGET_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 pixel_valid;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [INDEX_W-1:0]   pixel_index;
    logic                 visible;
    logic [COLOR_W-1:0]   red_out;
    logic [COLOR_W-1:0]   green_out;
    logic [COLOR_W-1:0]   blue_out;
    logic [COLOR_W-1:0]   alpha_out;
    logic                 last_pixel;

    // Bench copy of the target dimensions, as the block holds them after reset.
    logic [DIM_W-1:0] tgt_width = 7'd64;
    logic [DIM_W-1:0] tgt_height = 7'd64;

    segment_t segments_to_draw[$];
    pixel_t   pixels_due[$];
    int       mismatch_count = 0;
    int       gap_left = 0;
    bit       gaps_on = 1'b1;
    bit       req_taken = 1'b0;

    bresenham_line_rasterizer #(.TILE_SIZE(TILE)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .start_x(start_x),
        .start_y(start_y),
        .end_x(end_x),
        .end_y(end_y),
        .red_in(red_in),
        .green_in(green_in),
        .blue_in(blue_in),
        .alpha_in(alpha_in),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .pixel_index(pixel_index),
        .visible(visible),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .alpha_out(alpha_out),
        .last_pixel(last_pixel)
    );

    always #4 clk = ~clk;

    function automatic int tile_coord(input logic [COORD_W-1:0] c);
        return (int'(c) >= TILE) ? TILE - 1 : int'(c);
    endfunction

    // Walks the segment along its major axis and queues one pixel per step.
    function automatic void plot_segment(input segment_t seg);
        int x0, y0, x1, y1;
        int maj0, min0, maj1, min1, tmp;
        int dmaj, dmin, step, dec, mn, px, py, lin;
        bit steep;
        pixel_t pix;
        x0 = tile_coord(seg.sx);
        y0 = tile_coord(seg.sy);
        x1 = tile_coord(seg.ex);
        y1 = tile_coord(seg.ey);
        steep = ((y1 > y0) ? y1 - y0 : y0 - y1) >= ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (steep)
        begin
            maj0 = y0; min0 = x0; maj1 = y1; min1 = x1;
        end
        else
        begin
            maj0 = x0; min0 = y0; maj1 = x1; min1 = y1;
        end
        if (maj1 < maj0)
        begin
            tmp = maj0; maj0 = maj1; maj1 = tmp;
            tmp = min0; min0 = min1; min1 = tmp;
        end
        dmaj = maj1 - maj0;
        dmin = min1 - min0;
        step = 1;
        if (dmin < 0)
        begin
            step = -1;
            dmin = -dmin;
        end
        dec = 2 * dmin - dmaj;
        mn = min0;
        for (int maj = maj0; maj <= maj1; maj++)
        begin
            px = steep ? mn : maj;
            py = steep ? maj : mn;
            lin = px + py * int'(tgt_width);
            pix.x = px[COORD_W-1:0];
            pix.y = py[COORD_W-1:0];
            pix.lin_index = lin[INDEX_W-1:0];
            pix.visible = (px < int'(tgt_width)) && (py < int'(tgt_height));
            pix.red = seg.red;
            pix.green = seg.green;
            pix.blue = seg.blue;
            pix.alpha = seg.alpha;
            pix.last_flag = (maj == maj1);
            pixels_due.push_back(pix);
            if (dec > 0)
            begin
                mn += step;
                dec += 2 * (dmin - dmaj);
            end
            else
            begin
                dec += 2 * dmin;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(20, 90);
    endfunction

    // Moves a coordinate by up to +/- reach, kept inside the tile.
    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c, input int reach);
        int v;
        v = int'(c) + $urandom_range(0, 2 * reach) - reach;
        if (v < 0)
            v = 0;
        if (v > TILE - 1)
            v = TILE - 1;
        return v[COORD_W-1:0];
    endfunction

    function automatic segment_t random_segment();
        segment_t seg;
        int kind, len;
        logic [COORD_W-1:0] t;
        kind = $urandom_range(0, 9);
        seg.sx = COORD_W'($urandom_range(0, TILE - 1));
        seg.sy = COORD_W'($urandom_range(0, TILE - 1));
        seg.ex = COORD_W'($urandom_range(0, TILE - 1));
        seg.ey = COORD_W'($urandom_range(0, TILE - 1));
        seg.red = COLOR_W'($urandom_range(0, 255));
        seg.green = COLOR_W'($urandom_range(0, 255));
        seg.blue = COLOR_W'($urandom_range(0, 255));
        seg.alpha = COLOR_W'($urandom_range(0, 255));
        case (kind)
            5:
            begin
                seg.ex = nudge(seg.sx, 4);
                seg.ey = nudge(seg.sy, 4);
            end
            6: seg.ey = seg.sy;
            7: seg.ex = seg.sx;
            8:
            begin
                len = $urandom_range(0, TILE - 1);
                seg.sx = COORD_W'($urandom_range(0, TILE - 1 - len));
                seg.sy = COORD_W'($urandom_range(0, TILE - 1 - len));
                seg.ex = COORD_W'(int'(seg.sx) + len);
                seg.ey = COORD_W'(int'(seg.sy) + len);
                if ($urandom_range(0, 1) != 0)
                begin
                    t = seg.sx; seg.sx = seg.ex; seg.ex = t;
                end
            end
            9:
            begin
                // Corner and edge coordinates, sometimes collapsed to a point.
                seg.sx = ($urandom_range(0, 1) != 0) ? COORD_W'(TILE - 1) : '0;
                seg.ey = ($urandom_range(0, 1) != 0) ? COORD_W'(TILE - 1) : '0;
                if ($urandom_range(0, 2) == 0)
                begin
                    seg.ex = seg.sx;
                    seg.sy = seg.ey;
                end
            end
            default: ;
        endcase
        return seg;
    endfunction

    task automatic add_segment(input int sx, input int sy, input int ex, input int ey,
                               input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                               input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] a);
        segment_t seg;
        seg = '{sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0], ey[COORD_W-1:0],
                r, g, b, a};
        segments_to_draw.push_back(seg);
    endtask

    // Leaves cfg_valid high so that back-to-back writes never drop it in between.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_target(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        put_reg(brl_pkg::REG_TARGET_WIDTH, w);
        put_reg(brl_pkg::REG_TARGET_HEIGHT, h);
        put_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                DIM_W'($urandom_range(0, 127)));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_idle();
        do @(posedge clk);
        while (segments_to_draw.size() != 0 || start || busy || pixels_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Request driver: a request is held until taken, then the next follows after a random gap that may be empty.
    always @(negedge clk)
    begin
        segment_t seg;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (segments_to_draw.size() != 0)
            begin
                seg = segments_to_draw.pop_front();
                start_x <= seg.sx;
                start_y <= seg.sy;
                end_x <= seg.ex;
                end_y <= seg.ey;
                red_in <= seg.red;
                green_in <= seg.green;
                blue_in <= seg.blue;
                alpha_in <= seg.alpha;
                start <= 1'b1;
                gap_left = pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: tracks register writes and taken requests, and checks every pixel.
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    brl_pkg::REG_TARGET_WIDTH:  tgt_width = cfg_data;
                    brl_pkg::REG_TARGET_HEIGHT: tgt_height = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                req_taken = 1'b1;
                plot_segment('{start_x, start_y, end_x, end_y,
                               red_in, green_in, blue_in, alpha_in});
            end
            if (pixel_valid)
            begin
                got = {pixel_x, pixel_y, pixel_index, visible,
                       red_out, green_out, blue_out, alpha_out, last_pixel};
                if (pixels_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: pixel (%0d,%0d) arrived with none outstanding",
                                 $realtime, pixel_x, pixel_y);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: expected x=%0d y=%0d idx=%0d vis=%0b ",
                                      "rgba=%h%h%h%h last=%0b, got x=%0d y=%0d idx=%0d ",
                                      "vis=%0b rgba=%h%h%h%h last=%0b"}, $realtime,
                                     want.x, want.y, want.lin_index, want.visible,
                                     want.red, want.green, want.blue, want.alpha,
                                     want.last_flag, got.x, got.y, got.lin_index,
                                     got.visible, got.red, got.green, got.blue,
                                     got.alpha, got.last_flag);
                    end
                end
            end
        end
    end

    initial
    begin
        int widths[6];
        int heights[6];
        widths = '{1, 127, 0, 64, 37, 1};
        heights = '{1, 127, 0, 1, 50, 64};
        widths[4] = $urandom_range(2, 126);
        heights[4] = $urandom_range(2, 126);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments under the reset dimensions of 64 by 64.
        add_segment(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_segment(63, 63, 63, 63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_segment(0, 0, 63, 0, 8'hA5, 8'h5A, 8'hFF, 8'h00);
        add_segment(63, 63, 0, 63, 8'h5A, 8'hA5, 8'h00, 8'hFF);
        add_segment(0, 0, 0, 63, 8'h01, 8'h80, 8'h7F, 8'hFE);
        add_segment(63, 63, 63, 0, 8'hFE, 8'h7F, 8'h80, 8'h01);
        add_segment(0, 0, 63, 63, 8'hFF, 8'h00, 8'hFF, 8'h00);
        add_segment(63, 0, 0, 63, 8'h00, 8'hFF, 8'h00, 8'hFF);
        add_segment(0, 10, 63, 20, 8'h12, 8'h34, 8'h56, 8'h78);
        add_segment(63, 10, 0, 40, 8'h87, 8'h65, 8'h43, 8'h21);
        add_segment(5, 0, 20, 63, 8'hC3, 8'h3C, 8'h0F, 8'hF0);
        add_segment(40, 63, 2, 0, 8'h3C, 8'hC3, 8'hF0, 8'h0F);
        add_segment(0, 0, 1, 0, 8'hFF, 8'hFF, 8'h00, 8'h00);
        add_segment(0, 0, 1, 1, 8'h00, 8'h00, 8'hFF, 8'hFF);
        add_segment(0, 0, 2, 1, 8'hAA, 8'h55, 8'hAA, 8'h55);
        add_segment(10, 10, 9, 12, 8'h55, 8'hAA, 8'h55, 8'hAA);
        add_segment(21, 42, 42, 21, 8'h99, 8'h66, 8'h33, 8'hCC);
        add_segment(62, 1, 1, 62, 8'h66, 8'h99, 8'hCC, 8'h33);
        wait_for_idle();

        for (int p = 0; p < 6; p++)
        begin
            program_target(DIM_W'(widths[p]), DIM_W'(heights[p]));
            gaps_on = (p % 3 != 1);
            repeat (17) segments_to_draw.push_back(random_segment());
            wait_for_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("bresenham_line_rasterizer: match");
        else
            $display("bresenham_line_rasterizer: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("bresenham_line_rasterizer: mismatch");
        $finish;
    end

endmodule
